### hw/rtl/beam_histogram_pruner_macros.svh
// Assertion macros used by the beam histogram pruner checker.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef BEAM_HISTOGRAM_PRUNER_MACROS_SVH
`define BEAM_HISTOGRAM_PRUNER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BHP_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("beam_histogram_pruner assertion failed");

// Next-cycle implication, disabled during reset
`define BHP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("beam_histogram_pruner assertion failed");

`endif

### hw/rtl/bhp_pkg.sv
// Shared types, constants and the control store of the beam histogram pruner.
// No dependencies.
package bhp_pkg;

   localparam int CAPACITY_DEF  = 16;
   localparam int HANDLE_W      = 16;
   localparam int SCORE_W       = 32;
   localparam int OCC_W         = 5;
   localparam int CFG_W         = 4;
   localparam int MAX_RESULTS   = 15;
   localparam int REM_W         = $clog2(MAX_RESULTS + 1);
   localparam int RANK_DEPTH    = (2 ** CFG_W) - 1;
   localparam int RANK_IDX_W    = $clog2(RANK_DEPTH);

   localparam logic [CFG_W-1:0] TRIGGER_RESET = CFG_W'(10);
   localparam logic [CFG_W-1:0] KEEP_RESET    = CFG_W'(5);

   // Register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP    = 1'b1;

   // Step codes of the control program
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
   localparam logic [STEP_W-1:0] ST_FIND     = 4'd1;
   localparam logic [STEP_W-1:0] ST_CHECK    = 4'd2;
   localparam logic [STEP_W-1:0] ST_RANK_RD  = 4'd3;
   localparam logic [STEP_W-1:0] ST_RANK_USE = 4'd4;
   localparam logic [STEP_W-1:0] ST_THR      = 4'd5;
   localparam logic [STEP_W-1:0] ST_CNT_RD   = 4'd6;
   localparam logic [STEP_W-1:0] ST_CNT_USE  = 4'd7;
   localparam logic [STEP_W-1:0] ST_SETTLE   = 4'd8;
   localparam logic [STEP_W-1:0] ST_EM_RD    = 4'd9;
   localparam logic [STEP_W-1:0] ST_EM_USE   = 4'd10;
   localparam logic [STEP_W-1:0] ST_EMPTY    = 4'd11;

   // Wait selects: the step holds until its wait condition is met
   localparam logic [1:0] W_NONE = 2'd0;
   localparam logic [1:0] W_REQ  = 2'd1;
   localparam logic [1:0] W_OUT  = 2'd2;
   localparam logic [1:0] W_EMIT = 2'd3;

   // Jump conditions
   localparam logic [2:0] C_NEVER     = 3'd0;
   localparam logic [2:0] C_FULL      = 3'd1;
   localparam logic [2:0] C_FREE      = 3'd2;
   localparam logic [2:0] C_OVER      = 3'd3;
   localparam logic [2:0] C_LAST      = 3'd4;
   localparam logic [2:0] C_REM_ZERO  = 3'd5;
   localparam logic [2:0] C_EMIT_DONE = 3'd6;

   // Datapath operations
   localparam logic [3:0] OP_NOP    = 4'd0;
   localparam logic [3:0] OP_ACCEPT = 4'd1;
   localparam logic [3:0] OP_INSERT = 4'd2;
   localparam logic [3:0] OP_SETUP  = 4'd3;
   localparam logic [3:0] OP_READ   = 4'd4;
   localparam logic [3:0] OP_RANK   = 4'd5;
   localparam logic [3:0] OP_THR    = 4'd6;
   localparam logic [3:0] OP_TALLY  = 4'd7;
   localparam logic [3:0] OP_SETTLE = 4'd8;
   localparam logic [3:0] OP_EMIT   = 4'd9;
   localparam logic [3:0] OP_EMPTY  = 4'd10;

   typedef struct packed {
      logic [1:0]        wt_sel;
      logic [2:0]        cond_sel;
      logic [3:0]        op;
      logic [STEP_W-1:0] jmp;
      logic [STEP_W-1:0] nxt;
   } ucode_word_type;

   typedef struct packed {
      logic clear;
      logic push;
   } rank_ctl_type;

   function automatic ucode_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      w = '{wt_sel: W_NONE, cond_sel: C_NEVER, op: OP_NOP, jmp: ST_IDLE, nxt: ST_IDLE};
      unique case (step)
         ST_IDLE:     w = '{W_REQ,  C_FULL,      OP_ACCEPT, ST_CHECK,  ST_FIND};
         ST_FIND:     w = '{W_NONE, C_FREE,      OP_INSERT, ST_CHECK,  ST_FIND};
         ST_CHECK:    w = '{W_NONE, C_OVER,      OP_SETUP,  ST_RANK_RD, ST_EMPTY};
         ST_RANK_RD:  w = '{W_NONE, C_NEVER,     OP_READ,   ST_IDLE,   ST_RANK_USE};
         ST_RANK_USE: w = '{W_NONE, C_LAST,      OP_RANK,   ST_THR,    ST_RANK_RD};
         ST_THR:      w = '{W_NONE, C_NEVER,     OP_THR,    ST_IDLE,   ST_CNT_RD};
         ST_CNT_RD:   w = '{W_NONE, C_NEVER,     OP_READ,   ST_IDLE,   ST_CNT_USE};
         ST_CNT_USE:  w = '{W_NONE, C_LAST,      OP_TALLY,  ST_SETTLE, ST_CNT_RD};
         ST_SETTLE:   w = '{W_NONE, C_REM_ZERO,  OP_SETTLE, ST_EMPTY,  ST_EM_RD};
         ST_EM_RD:    w = '{W_NONE, C_NEVER,     OP_READ,   ST_IDLE,   ST_EM_USE};
         ST_EM_USE:   w = '{W_EMIT, C_EMIT_DONE, OP_EMIT,   ST_IDLE,   ST_EM_RD};
         ST_EMPTY:    w = '{W_OUT,  C_NEVER,     OP_EMPTY,  ST_IDLE,   ST_IDLE};
         default:     w = '{W_NONE, C_NEVER,     OP_NOP,    ST_IDLE,   ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

### hw/rtl/beam_histogram_pruner.sv
// Beam histogram pruner: a store of CAPACITY scored hypotheses with histogram
// pruning. Each request inserts one entry into the first free slot (dropped
// when the store is full). When occupancy then exceeds prune_trigger, the
// prune_keep-th best score (or the lowest, with fewer entries) becomes the
// threshold and every entry scoring strictly below it is removed, at most 15
// per request, lowest slots first; one response per removed handle, or one
// response with removed_valid low when nothing is removed. Every response of
// a request carries the final occupancy. A small control program steps a
// shared datapath around one RAM with one write port and one read port
// holding handles and scores. A request without pruning scans from slot 0 to
// the first free slot (no scan when the store is full), then checks the
// occupancy and responds. A pruning request adds two full passes over the
// store (rank, then count) and, when entries go, an emit pass that stops at
// the last removed slot, each reading the RAM for a slot and then using the
// word; response stalls can hold the emit pass. The next request is taken
// while the last response still waits in the output register.
// Depends on bhp_pkg, bhp_ram and bhp_rank.
module beam_histogram_pruner #(
   parameter int CAPACITY = bhp_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [bhp_pkg::HANDLE_W-1:0]         req_entry_handle,
   input  logic signed [bhp_pkg::SCORE_W-1:0]   req_entry_score,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [bhp_pkg::HANDLE_W-1:0]         rsp_removed_handle,
   output logic                                 rsp_removed_valid,
   output logic                                 rsp_last_result,
   output logic [bhp_pkg::OCC_W-1:0]            rsp_occupancy,
   input  logic                                 csr_wr_en,
   input  logic [bhp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bhp_pkg::CFG_W-1:0]            csr_wr_data
);
   import bhp_pkg::*;

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int WIDE_W = CNT_W + OCC_W;
   localparam int WORD_W = HANDLE_W + SCORE_W;

   // Control
   logic [STEP_W-1:0]  step_ff, step_in;
   ucode_word_type     uword;
   logic               go;
   logic               cond;

   // Datapath state
   logic [IDX_W-1:0]          idx_ff, idx_in, idx_next;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CAPACITY-1:0]       used_ff, used_in;
   logic [CFG_W-1:0]          trig_ff, trig_in;
   logic [CFG_W-1:0]          keep_ff, keep_in;
   logic [HANDLE_W-1:0]       hdl_ff, hdl_in;
   logic signed [SCORE_W-1:0] scr_ff, scr_in;
   logic signed [SCORE_W-1:0] thr_ff, thr_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [REM_W-1:0]          emitted_ff, emitted_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0] rsp_hdl_ff, rsp_hdl_in;
   logic                rsp_rv_ff, rsp_rv_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;

   // RAM and ranking
   logic                      ram_wr_en;
   logic                      ram_rd_en;
   logic [WORD_W-1:0]         ram_rd_data;
   logic [HANDLE_W-1:0]       rd_handle;
   logic signed [SCORE_W-1:0] rd_score;
   rank_ctl_type              rank_ctl;
   logic [RANK_IDX_W-1:0]     rank_sel;
   logic signed [SCORE_W-1:0] rank_score;

   // Derived
   logic              used_cur;
   logic              hit;
   logic              last_slot;
   logic              out_free;
   logic              emit_last;
   logic [WIDE_W-1:0] count_wide, trig_wide, kk_wide;
   logic [CFG_W-1:0]  kk;
   logic [CFG_W-1:0]  k_sel;

   assign uword     = ucode_rom(step_ff);
   assign rd_handle = ram_rd_data[WORD_W-1:SCORE_W];
   assign rd_score  = ram_rd_data[SCORE_W-1:0];
   assign used_cur  = used_ff[idx_ff];
   assign hit       = used_cur && (rd_score < thr_ff);
   assign last_slot = (idx_ff == IDX_W'(CAPACITY - 1));
   assign idx_next  = last_slot ? '0 : idx_ff + 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_last = ((emitted_ff + REM_W'(1)) == rem_ff);

   assign count_wide = {{OCC_W{1'b0}}, count_ff};
   assign trig_wide  = {{(WIDE_W - CFG_W){1'b0}}, trig_ff};
   assign kk         = (keep_ff == '0) ? CFG_W'(1) : keep_ff;
   assign kk_wide    = {{(WIDE_W - CFG_W){1'b0}}, kk};
   assign k_sel      = (count_wide < kk_wide) ? count_wide[CFG_W-1:0] : kk;
   assign rank_sel   = RANK_IDX_W'(k_sel - 1'b1);

   // Step sequencing
   always_comb begin
      unique case (uword.wt_sel)
         W_NONE: go = 1'b1;
         W_REQ:  go = req_valid;
         W_OUT:  go = out_free;
         W_EMIT: go = !hit || out_free;
      endcase
      unique case (uword.cond_sel)
         C_NEVER:     cond = 1'b0;
         C_FULL:      cond = (count_ff == CNT_W'(CAPACITY));
         C_FREE:      cond = !used_cur;
         C_OVER:      cond = (count_wide > trig_wide);
         C_LAST:      cond = last_slot;
         C_REM_ZERO:  cond = (rem_ff == '0);
         C_EMIT_DONE: cond = hit && emit_last;
         default:     cond = 1'b0;
      endcase
      if (go) begin
         step_in = cond ? uword.jmp : uword.nxt;
      end else begin
         step_in = step_ff;
      end
   end

   assign req_ready = (step_ff == ST_IDLE);

   // Datapath
   always_comb begin
      idx_in       = idx_ff;
      count_in     = count_ff;
      used_in      = used_ff;
      hdl_in       = hdl_ff;
      scr_in       = scr_ff;
      thr_in       = thr_ff;
      rem_in       = rem_ff;
      emitted_in   = emitted_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      rank_ctl     = '{clear: 1'b0, push: 1'b0};
      rsp_hdl_in   = rsp_hdl_ff;
      rsp_rv_in    = rsp_rv_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_occ_in   = rsp_occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (go) begin
         unique case (uword.op)
            OP_NOP: begin
            end
            OP_ACCEPT: begin
               hdl_in = req_entry_handle;
               scr_in = req_entry_score;
               idx_in = '0;
            end
            OP_INSERT: begin
               if (!used_cur) begin
                  ram_wr_en       = 1'b1;
                  used_in[idx_ff] = 1'b1;
                  count_in        = count_ff + 1'b1;
               end else begin
                  idx_in = idx_next;
               end
            end
            OP_SETUP: begin
               idx_in         = '0;
               rem_in         = '0;
               rank_ctl.clear = 1'b1;
            end
            OP_READ: begin
               ram_rd_en = 1'b1;
            end
            OP_RANK: begin
               rank_ctl.push = used_cur;
               idx_in        = idx_next;
            end
            OP_THR: begin
               thr_in = rank_score;
               idx_in = '0;
            end
            OP_TALLY: begin
               if (hit && (rem_ff != REM_W'(MAX_RESULTS))) begin
                  rem_in = rem_ff + 1'b1;
               end
               idx_in = idx_next;
            end
            OP_SETTLE: begin
               count_in   = count_ff - CNT_W'(rem_ff);
               idx_in     = '0;
               emitted_in = '0;
            end
            OP_EMIT: begin
               if (hit) begin
                  used_in[idx_ff] = 1'b0;
                  emitted_in      = emitted_ff + 1'b1;
                  rsp_valid_in    = 1'b1;
                  rsp_hdl_in      = rd_handle;
                  rsp_rv_in       = 1'b1;
                  rsp_last_in     = emit_last;
                  rsp_occ_in      = count_wide[OCC_W-1:0];
               end
               idx_in = idx_next;
            end
            OP_EMPTY: begin
               rsp_valid_in = 1'b1;
               rsp_hdl_in   = '0;
               rsp_rv_in    = 1'b0;
               rsp_last_in  = 1'b1;
               rsp_occ_in   = count_wide[OCC_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Configuration writes
   always_comb begin
      trig_in = trig_ff;
      keep_in = keep_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TRIGGER: trig_in = csr_wr_data;
            CSR_KEEP:    keep_in = csr_wr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         count_ff     <= '0;
         used_ff      <= '0;
         trig_ff      <= TRIGGER_RESET;
         keep_ff      <= KEEP_RESET;
         idx_ff       <= '0;
         rem_ff       <= '0;
         emitted_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         trig_ff      <= trig_in;
         keep_ff      <= keep_in;
         idx_ff       <= idx_in;
         rem_ff       <= rem_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdl_ff      <= hdl_in;
      scr_ff      <= scr_in;
      thr_ff      <= thr_in;
      rsp_hdl_ff  <= rsp_hdl_in;
      rsp_rv_ff   <= rsp_rv_in;
      rsp_last_ff <= rsp_last_in;
      rsp_occ_ff  <= rsp_occ_in;
   end

   bhp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CAPACITY)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data ({hdl_ff, scr_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   bhp_rank #(
      .DEPTH (RANK_DEPTH)
   ) u_rank (
      .clock      (clock),
      .reset      (reset),
      .ctl        (rank_ctl),
      .push_score (rd_score),
      .sel_idx    (rank_sel),
      .sel_score  (rank_score)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_removed_handle = rsp_hdl_ff;
   assign rsp_removed_valid  = rsp_rv_ff;
   assign rsp_last_result    = rsp_last_ff;
   assign rsp_occupancy      = rsp_occ_ff;

endmodule

### hw/rtl/bhp_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bhp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bhp_rank.sv
// Sorted list of the best scores seen in one ranking pass, best first.
// Depends on bhp_pkg.
module bhp_rank #(
   parameter int DEPTH = bhp_pkg::RANK_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bhp_pkg::rank_ctl_type             ctl,
   input  logic signed [bhp_pkg::SCORE_W-1:0] push_score,
   input  logic [$clog2(DEPTH)-1:0]          sel_idx,
   output logic signed [bhp_pkg::SCORE_W-1:0] sel_score
);
   import bhp_pkg::*;

   logic signed [SCORE_W-1:0] val_ff   [DEPTH];
   logic signed [SCORE_W-1:0] val_in   [DEPTH];
   logic signed [SCORE_W-1:0] prev_val [DEPTH];
   logic [DEPTH-1:0]          vld_ff;
   logic [DEPTH-1:0]          vld_in;
   logic [DEPTH-1:0]          ge;
   logic [DEPTH-1:0]          prev_ge;
   logic [DEPTH-1:0]          prev_vld;

   // Each cell keeps its value, takes the new score, or takes its upper neighbor
   always_comb begin
      for (int j = 0; j < DEPTH; j++) begin
         ge[j] = vld_ff[j] && (val_ff[j] >= push_score);
      end
      prev_val[0] = push_score;
      prev_vld[0] = 1'b1;
      prev_ge[0]  = 1'b1;
      for (int j = 1; j < DEPTH; j++) begin
         prev_val[j] = val_ff[j-1];
         prev_vld[j] = vld_ff[j-1];
         prev_ge[j]  = ge[j-1];
      end
      for (int j = 0; j < DEPTH; j++) begin
         val_in[j] = val_ff[j];
         vld_in[j] = vld_ff[j];
         if (ctl.clear) begin
            vld_in[j] = 1'b0;
         end else if (ctl.push && !ge[j]) begin
            if (prev_ge[j]) begin
               val_in[j] = push_score;
               vld_in[j] = 1'b1;
            end else begin
               val_in[j] = prev_val[j];
               vld_in[j] = prev_vld[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DEPTH; j++) begin
         val_ff[j] <= val_in[j];
      end
   end

   assign sel_score = val_ff[sel_idx];

endmodule

### hw/rtl/bhp_checker.sv
// Port-level checks for the beam histogram pruner, bound to the top level.
// Depends on bhp_pkg and beam_histogram_pruner_macros.svh.
`include "beam_histogram_pruner_macros.svh"

module bhp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [bhp_pkg::HANDLE_W-1:0]       rsp_removed_handle,
   input logic                               rsp_removed_valid,
   input logic                               rsp_last_result,
   input logic [bhp_pkg::OCC_W-1:0]          rsp_occupancy
);
   import bhp_pkg::*;

   // A stalled response holds its payload
   `BHP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_removed_handle) && $stable(rsp_removed_valid) && $stable(rsp_last_result) && $stable(rsp_occupancy))

   // An empty response is the only and last one, with a zero handle
   `BHP_ASSERT_IMP(a_empty_rsp, rsp_valid && !rsp_removed_valid, rsp_last_result && (rsp_removed_handle == '0))

   // A taken request leaves the block busy in the next cycle
   `BHP_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)

   // More responses pending for this request: no new request yet
   `BHP_ASSERT_IMP(a_busy_mid_burst, rsp_valid && !rsp_last_result, !req_ready)

endmodule

bind beam_histogram_pruner bhp_checker u_bhp_checker (.*);

### sim/tb_top.sv
// Self-checking testbench for beam_histogram_pruner: inserts scored entries,
// predicts every prune response in a scoreboard class and checks them in order.
// Depends on bhp_pkg and the beam_histogram_pruner RTL.
module tb_top;
   import bhp_pkg::*;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic                removed;
      logic                last;
      logic [OCC_W-1:0]    occupancy;
   } prune_result_type;

   class prune_scoreboard_type;
      logic [HANDLE_W-1:0]        slot_handle [CAPACITY_DEF];
      logic signed [SCORE_W-1:0]  slot_score [CAPACITY_DEF];
      bit                         slot_busy [CAPACITY_DEF];
      int                         occupied;
      logic [CFG_W-1:0]           prune_trigger;
      logic [CFG_W-1:0]           prune_keep;
      prune_result_type           pending_results[$];
      int                         errors;
      int                         requests;
      int                         drops;
      int                         responses;
      int                         removals;

      function new();
         foreach (slot_busy[i]) slot_busy[i] = 1'b0;
         occupied = 0;
         prune_trigger = TRIGGER_RESET;
         prune_keep = KEEP_RESET;
         errors = 0;
         requests = 0;
         drops = 0;
         responses = 0;
         removals = 0;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // Insert into the first free slot, then, past the trigger, prune below the keep-th best score.
      function void note_request(logic [HANDLE_W-1:0] h, logic signed [SCORE_W-1:0] s);
         prune_result_type          batch[$];
         prune_result_type          r;
         logic signed [SCORE_W-1:0] ranked [CAPACITY_DEF];
         logic signed [SCORE_W-1:0] thr;
         int                        n;
         int                        j;
         int                        rank;
         requests++;
         if (occupied < CAPACITY_DEF) begin
            for (int i = 0; i < CAPACITY_DEF; i++) begin
               if (!slot_busy[i]) begin
                  slot_busy[i] = 1'b1;
                  slot_handle[i] = h;
                  slot_score[i] = s;
                  occupied++;
                  break;
               end
            end
         end else begin
            drops++;
         end
         if (occupied > prune_trigger) begin
            n = 0;
            for (int i = 0; i < CAPACITY_DEF; i++) begin
               if (slot_busy[i]) begin
                  j = n;
                  while (j > 0 && ranked[j-1] < slot_score[i]) begin
                     ranked[j] = ranked[j-1];
                     j--;
                  end
                  ranked[j] = slot_score[i];
                  n++;
               end
            end
            rank = (prune_keep == 0) ? 1 : prune_keep;
            if (rank > n) rank = n;
            if (rank > 0) begin
               thr = ranked[rank-1];
               for (int i = 0; i < CAPACITY_DEF && batch.size() < MAX_RESULTS; i++) begin
                  if (slot_busy[i] && slot_score[i] < thr) begin
                     slot_busy[i] = 1'b0;
                     occupied--;
                     r = '0;
                     r.handle = slot_handle[i];
                     r.removed = 1'b1;
                     batch.push_back(r);
                  end
               end
            end
         end
         if (batch.size() == 0) begin
            r = '0;
            batch.push_back(r);
         end
         foreach (batch[i]) begin
            r = batch[i];
            r.occupancy = OCC_W'(occupied);
            r.last = (i == batch.size() - 1);
            pending_results.push_back(r);
         end
      endfunction

      task report_mismatch(string what, int unsigned want, int unsigned got);
         errors++;
         if (errors <= 40)
            $display("mismatch at response %0d: %s, expected 0x%0h, got 0x%0h",
                     responses, what, want, got);
      endtask

      task check_response(prune_result_type got);
         prune_result_type want;
         responses++;
         if (got.removed) removals++;
         if (pending_results.size() == 0) begin
            report_mismatch("response with no request pending", 0, got);
            return;
         end
         want = pending_results.pop_front();
         if (got.handle != want.handle)
            report_mismatch("removed_handle", want.handle, got.handle);
         if (got.removed != want.removed)
            report_mismatch("removed_valid", want.removed, got.removed);
         if (got.last != want.last)
            report_mismatch("last_result", want.last, got.last);
         if (got.occupancy != want.occupancy)
            report_mismatch("occupancy", want.occupancy, got.occupancy);
      endtask
   endclass

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [HANDLE_W-1:0]        req_entry_handle = '0;
   logic signed [SCORE_W-1:0]  req_entry_score = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [HANDLE_W-1:0]        rsp_removed_handle;
   logic                       rsp_removed_valid;
   logic                       rsp_last_result;
   logic [OCC_W-1:0]           rsp_occupancy;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = CSR_TRIGGER;
   logic [CFG_W-1:0]           csr_wr_data = '0;

   int                         req_idle_pct = 0;
   int                         rsp_stall_pct = 0;
   int                         settings_applied = 0;
   prune_scoreboard_type       sb = new();

   beam_histogram_pruner dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_entry_handle   (req_entry_handle),
      .req_entry_score    (req_entry_score),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_removed_handle (rsp_removed_handle),
      .rsp_removed_valid  (rsp_removed_valid),
      .rsp_last_result    (rsp_last_result),
      .rsp_occupancy      (rsp_occupancy),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Sample at the falling edge: a response seen here transfers at the next rising edge.
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response('{rsp_removed_handle, rsp_removed_valid, rsp_last_result,
                             rsp_occupancy});
   end

   task automatic send_request(input logic [HANDLE_W-1:0] h,
                               input logic signed [SCORE_W-1:0] s);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_entry_handle <= h;
      req_entry_score <= s;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      sb.note_request(h, s);
   endtask

   // Drain all responses before touching the limits.
   task automatic apply_limits(input logic [CFG_W-1:0] trig, input logic [CFG_W-1:0] kp);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TRIGGER;
      csr_wr_data <= trig;
      @(posedge clock);
      csr_index <= CSR_KEEP;
      csr_wr_data <= kp;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.prune_trigger = trig;
      sb.prune_keep = kp;
      settings_applied++;
   endtask

   function automatic logic [HANDLE_W-1:0] pick_handle();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 5) return '0;
      if (sel < 10) return '1;
      return HANDLE_W'($urandom_range(65535));
   endfunction

   function automatic logic signed [SCORE_W-1:0] pick_score();
      int unsigned sel;
      sel = $urandom_range(199);
      // keep the top score rare: an entry holding it can never be pruned
      if (sel == 0) return {1'b0, {(SCORE_W-1){1'b1}}};
      if (sel < 10) return {1'b1, {(SCORE_W-1){1'b0}}};
      if (sel < 20) return '1;
      if (sel < 80) return SCORE_W'($urandom_range(4)) << 16;
      return $urandom;
   endfunction

   initial begin
      logic [CFG_W-1:0] trig_set [8];
      logic [CFG_W-1:0] keep_set [8];
      trig_set = '{4'd10, 4'd15, 4'd0, 4'd1, 4'd15, 4'd2, 4'd0, 4'd0};
      keep_set = '{4'd5, 4'd15, 4'd0, 4'd1, 4'd1, 4'd15, 4'd0, 4'd0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // prune on every request, keeping only the best score and its ties
      apply_limits(4'd0, 4'd0);
      send_request(16'h0000, 32'sh8000_0000);
      send_request(16'hFFFF, 32'sh4000_0000);
      send_request(16'h1234, 32'sh4000_0000);
      send_request(16'hABCD, 32'shFFFF_FFFF);
      // keep rank above occupancy: threshold is the lowest score
      apply_limits(4'd3, 4'd15);
      send_request(16'h0101, -(32'sd5 <<< 16));
      send_request(16'h0202, -(32'sd6 <<< 16));
      // several removals in one prune
      apply_limits(4'd5, 4'd1);
      send_request(16'h0303, 32'sh0001_8000);
      send_request(16'h0404, 32'sh0000_0001);
      // fill the store with ties, then push one more into a full store
      apply_limits(4'd15, 4'd15);
      for (int i = 0; i < 14; i++) send_request(16'h5000 + 16'(i), '0);
      send_request(16'hFFFF, 32'sh7FFF_FFFF);

      trig_set[6] = CFG_W'($urandom_range(15));
      keep_set[6] = CFG_W'($urandom_range(15));
      trig_set[7] = CFG_W'($urandom_range(15));
      keep_set[7] = CFG_W'($urandom_range(15));
      for (int p = 0; p < 8; p++) begin
         apply_limits(trig_set[p], keep_set[p]);
         unique case (p % 4)
            0: begin
               req_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct = 71;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct = 0;
               rsp_stall_pct = 71;
            end
            default: begin
               req_idle_pct = 10;
               rsp_stall_pct = 10;
            end
         endcase
         repeat (50) send_request(pick_handle(), pick_score());
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d requests (%0d dropped on a full store), %0d responses, %0d removals",
               sb.requests, sb.drops, sb.responses, sb.removals);
      $display("across %0d limit settings with sender gaps and receiver stalls",
               settings_applied);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d responses still pending", sb.pending());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
